[rtl/repeat_address_gate_assert.svh]
// Assertion macros for the repeat address gate
`ifndef REPEAT_ADDRESS_GATE_ASSERT_SVH
`define REPEAT_ADDRESS_GATE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define RAG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("repeat_address_gate: assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define RAG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("repeat_address_gate: assertion failed");

`endif

[rtl/rag_pkg.sv]
// Shared types and constants for the repeat address gate
package rag_pkg;

  localparam int unsigned ADDR_W            = 48;
  localparam int unsigned TIME_W            = 48;
  localparam int unsigned CFG_W             = 32;
  localparam int unsigned HELD_W            = 8;
  localparam int unsigned DEF_HISTORY_DEPTH = 128;

  localparam logic [CFG_W-1:0] RST_REPEAT_WINDOW = 32'd900000;
  localparam logic [CFG_W-1:0] RST_EXPIRY        = 32'(60 * 60 * 1000);

  typedef enum logic {
    REG_REPEAT_WINDOW = 1'b0,
    REG_EXPIRY        = 1'b1
  } rag_reg_e;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_PURGE = 1'b1
  } rag_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_PURGE,
    ST_EMIT
  } rag_state_e;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [ADDR_W-1:0] addr;
  } rag_entry_t;

endpackage

[rtl/rag_if.sv]
// Valid/ready channel interfaces for request and result items
interface rag_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [rag_pkg::ADDR_W-1:0] address;
  logic [rag_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, operation, address, now_ms, input ready);
  modport sink   (input valid, operation, address, now_ms, output ready);
endinterface

interface rag_out_if;
  logic                       valid;
  logic                       ready;
  logic                       allowed;
  logic [rag_pkg::HELD_W-1:0] entries_held;

  modport source (output valid, allowed, entries_held, input ready);
  modport sink   (input valid, allowed, entries_held, output ready);
endinterface

[rtl/repeat_address_gate.sv]
// Repeat address gate: FIFO history of advertising addresses with first-seen times
// A check item walks the history oldest first, one entry per cycle through the
// single read port of the entry memory. A purge item drops one expired entry
// per cycle, oldest first, and stops at the first entry that has not expired
// or when the history is empty. One item is in work at a time; the input is
// ready only while the sequencer is idle, and a finished result waits in an
// output register until taken. The history needs no clearing after reset.
`include "repeat_address_gate_assert.svh"

module repeat_address_gate #(
  parameter int unsigned HISTORY_DEPTH = rag_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [rag_pkg::CFG_W-1:0] cfg_wdata_i,
  rag_in_if.sink                    in_i,
  rag_out_if.source                 out_o
);
  import rag_pkg::*;

  localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W = TIME_W + 1;
  localparam logic [CNT_W:0] DEPTH_EXT = (CNT_W + 1)'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] base,
                                               logic [CNT_W-1:0] offs);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offs);
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[PTR_W-1:0];
  endfunction

  rag_entry_t mem [HISTORY_DEPTH];
  rag_entry_t rd_q;

  rag_state_e        state_q, state_d;
  logic [CFG_W-1:0]  window_q, expiry_q;
  logic [PTR_W-1:0]  oldest_q, oldest_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              op_q, op_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic              allowed_q, allowed_d;
  logic              out_valid_q, out_valid_d;
  logic              out_allowed_q, out_allowed_d;
  logic [HELD_W-1:0] out_held_q, out_held_d;

  logic [PTR_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  wr_slot;
  logic              mem_we;
  logic              in_fire;
  logic              out_free;
  logic              hit;
  logic              last_idx;
  logic              fresh;
  logic              expired;
  logic [CNT_W-1:0]  idx_next;
  logic [SUM_W-1:0]  limit_sum;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign idx_next = idx_q + CNT_W'(1);
  assign hit      = rd_q.addr == addr_q;
  assign last_idx = idx_next == count_q;
  assign limit_sum = SUM_W'(rd_q.stamp) +
                     SUM_W'((state_q == ST_PURGE) ? expiry_q : window_q);
  assign fresh    = SUM_W'(now_q) < limit_sum;
  assign expired  = !fresh;

  assign in_i.ready         = state_q == ST_IDLE;
  assign out_o.valid        = out_valid_q;
  assign out_o.allowed      = out_allowed_q;
  assign out_o.entries_held = out_held_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.operation == OP_CHECK) begin
            state_d = (count_q == '0) ? ST_INSERT : ST_SCAN;
          end else begin
            state_d = (count_q == '0) ? ST_EMIT : ST_PURGE;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_EMIT;
        end else if (last_idx) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: state_d = ST_EMIT;
      ST_PURGE: begin
        if (!expired || count_q == CNT_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    oldest_d      = oldest_q;
    count_d       = count_q;
    idx_d         = idx_q;
    op_d          = op_q;
    addr_d        = addr_q;
    now_d         = now_q;
    allowed_d     = allowed_q;
    out_allowed_d = out_allowed_q;
    out_held_d    = out_held_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    rd_addr       = oldest_q;
    wr_slot       = oldest_q;
    mem_we        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d      = in_i.operation;
          addr_d    = in_i.address;
          now_d     = in_i.now_ms;
          idx_d     = '0;
          allowed_d = 1'b0;
        end
      end
      ST_SCAN: begin
        rd_addr = ptr_add(oldest_q, idx_next);
        if (hit) begin
          allowed_d = fresh;
        end else begin
          idx_d = idx_next;
        end
      end
      ST_INSERT: begin
        mem_we    = 1'b1;
        allowed_d = 1'b1;
        if (count_q == DEPTH_CNT) begin
          wr_slot  = oldest_q;
          oldest_d = ptr_add(oldest_q, CNT_W'(1));
        end else begin
          wr_slot = ptr_add(oldest_q, count_q);
          count_d = count_q + CNT_W'(1);
        end
      end
      ST_PURGE: begin
        rd_addr = ptr_add(oldest_q, CNT_W'(1));
        if (expired) begin
          oldest_d = ptr_add(oldest_q, CNT_W'(1));
          count_d  = count_q - CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_allowed_d = allowed_q && (op_q == OP_CHECK);
          out_held_d    = HELD_W'(count_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_slot] <= '{stamp: now_q, addr: addr_q};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= RST_REPEAT_WINDOW;
      expiry_q    <= RST_EXPIRY;
      oldest_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REPEAT_WINDOW: window_q <= cfg_wdata_i;
          REG_EXPIRY:        expiry_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    op_q          <= op_d;
    addr_q        <= addr_d;
    now_q         <= now_d;
    allowed_q     <= allowed_d;
    out_allowed_q <= out_allowed_d;
    out_held_q    <= out_held_d;
  end

  `RAG_ASSERT_IMP(a_count_bound, 1'b1, count_q <= DEPTH_CNT)
  `RAG_ASSERT_IMP(a_oldest_bound, 1'b1, 32'(oldest_q) < HISTORY_DEPTH)
  `RAG_ASSERT_NXT(a_purge_no_growth, state_q == ST_PURGE, count_q <= $past(count_q))
  `RAG_ASSERT_NXT(a_emit_loads_out, state_q == ST_EMIT && out_free, out_valid_q)
  `RAG_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, idx_q < count_q)

endmodule
